// ===== hdl/priority_annunciation_sequencer_unit_defines.svh =====
// assertion macros for the priority annunciation sequencer checker
// used by pas_checker.sv, expects i_clk and i_rst_n in scope
`ifndef PRIORITY_ANNUNCIATION_SEQUENCER_UNIT_DEFINES_SVH
`define PRIORITY_ANNUNCIATION_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define PAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pas_pkg.sv =====
// shared types and constants for the priority annunciation sequencer
// no dependencies
`default_nettype none

package pas_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int PRIO_LEVELS     = 8;

    localparam int CODE_W    = 6;
    localparam int DUR_W     = 16;
    localparam int PRIO_W    = 3;
    localparam int VOL_W     = 8;
    localparam int ELAPSED_W = 17;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
    localparam logic [VOL_W-1:0]     VOLUME_RESET = 8'hFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        EV_PLAY = 2'd0,
        EV_STOP = 2'd1,
        EV_DROP = 2'd2,
        EV_FULL = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_P2WAIT,
        ST_P2EMIT
    } t_back_state;

    typedef struct packed {
        logic              is_tick;
        logic [CODE_W-1:0] code;
        logic [DUR_W-1:0]  dur;
        logic [PRIO_W-1:0] prio;
        logic              last;
    } t_item;

    typedef struct packed {
        logic              last;
        logic [DUR_W-1:0]  dur;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        t_event_kind       kind;
        logic [CODE_W-1:0] code;
        logic [VOL_W-1:0]  vol;
        logic              last;
    } t_event;

endpackage

`default_nettype wire

// ===== hdl/pas_front.sv =====
// front end: accepts words, classifies them and holds them in a short queue
// depends on pas_pkg
`default_nettype none

module pas_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_is_tick,
    input  logic [pas_pkg::CODE_W-1:0]  i_code,
    input  logic [pas_pkg::DUR_W-1:0]   i_dur,
    input  logic [pas_pkg::PRIO_W-1:0]  i_prio,
    input  logic                        i_last,
    output pas_pkg::t_item              o_item,
    output logic                        o_item_valid,
    input  logic                        i_pop
);
    import pas_pkg::*;

    t_item                 r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    t_item                 n_item;
    logic                  push;
    logic                  pop;

    assign o_ready      = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_buf[r_rd_ptr];
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && o_item_valid;

    // priority saturates to the top level
    always_comb begin
        n_item.is_tick = i_is_tick;
        n_item.code    = i_code;
        n_item.dur     = i_dur;
        n_item.prio    = (i_prio > PRIO_W'(PRIO_LEVELS - 1)) ? PRIO_W'(PRIO_LEVELS - 1) : i_prio;
        n_item.last    = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pas_back.sv =====
// back end: element store, priority decision, playback sequencing, output register
// depends on pas_pkg
`default_nettype none

module pas_back #(
    parameter int QUEUE_DEPTH = pas_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pas_pkg::VOL_W-1:0]  i_cfg_wdata,
    input  pas_pkg::t_item             i_item,
    input  logic                       i_item_valid,
    output logic                       o_pop,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output pas_pkg::t_event            o_out
);
    import pas_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry                r_mem [QUEUE_DEPTH];
    t_entry                r_rd;
    t_back_state           r_state;
    t_back_state           n_state;
    t_item                 r_item;
    logic [VOL_W-1:0]      r_volume;
    logic [PTR_W-1:0]      r_head;
    logic [PTR_W-1:0]      r_tail;
    logic [CNT_W-1:0]      r_count;
    logic [PRIO_W-1:0]     r_qprio;
    logic                  r_playing;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic                  r_mid;
    logic                  r_disc;
    logic                  r_o_valid;
    t_event                r_o;

    logic [PTR_W-1:0]      n_head;
    logic [PTR_W-1:0]      n_tail;
    logic [CNT_W-1:0]      n_count;
    logic [PRIO_W-1:0]     n_qprio;
    logic                  n_playing;
    logic [ELAPSED_W-1:0]  n_elapsed;
    logic                  n_mid;
    logic                  n_disc;

    logic                  disc;
    logic [PTR_W-1:0]      tl;
    logic [CNT_W-1:0]      cnt;
    logic [ELAPSED_W-1:0]  el_inc;
    logic                  ev_valid;
    t_event                ev;
    logic                  need_second;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  out_free;
    logic                  upd;

    assign out_free    = !r_o_valid || i_out_ready;
    assign o_pop       = (r_state == ST_IDLE) && i_item_valid;
    assign o_out_valid = r_o_valid;
    assign o_out       = r_o;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_qprio     = r_qprio;
        n_playing   = r_playing;
        n_elapsed   = r_elapsed;
        n_mid       = r_mid;
        n_disc      = r_disc;
        disc        = r_disc;
        tl          = r_tail;
        cnt         = r_count;
        el_inc      = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
        ev_valid    = 1'b0;
        ev.kind     = EV_PLAY;
        ev.code     = '0;
        ev.vol      = '0;
        ev.last     = 1'b1;
        need_second = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        case (r_state)
            ST_EXEC: begin
                if (!r_item.is_tick) begin
                    if (!r_mid) begin
                        disc = 1'b0;
                        if (r_count != '0 && r_qprio > r_item.prio) begin
                            disc     = 1'b1;
                            ev_valid = 1'b1;
                            ev.kind  = EV_DROP;
                        end else begin
                            if (r_count != '0 && r_qprio < r_item.prio) begin
                                if (r_playing) begin
                                    ev_valid = 1'b1;
                                    ev.kind  = EV_STOP;
                                    ev.code  = r_rd.code;
                                end
                                n_head    = '0;
                                tl        = '0;
                                cnt       = '0;
                                n_playing = 1'b0;
                                n_elapsed = '0;
                            end
                            n_qprio = r_item.prio;
                        end
                    end
                    if (!disc) begin
                        if (cnt == CNT_W'(QUEUE_DEPTH)) begin
                            ev_valid = 1'b1;
                            ev.kind  = EV_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = tl;
                            tl      = (tl == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tl + 1'b1;
                            cnt     = cnt + 1'b1;
                        end
                    end
                    n_tail  = tl;
                    n_count = cnt;
                    n_mid   = !r_item.last;
                    n_disc  = r_item.last ? 1'b0 : disc;
                end else if (r_count != '0) begin
                    if (!r_playing) begin
                        ev_valid  = 1'b1;
                        ev.kind   = EV_PLAY;
                        ev.code   = r_rd.code;
                        ev.vol    = r_volume;
                        n_playing = 1'b1;
                        n_elapsed = '0;
                    end else if (el_inc > {1'b0, r_rd.dur}) begin
                        ev_valid    = 1'b1;
                        ev.kind     = EV_STOP;
                        ev.code     = r_rd.code;
                        n_head      = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        n_count     = r_count - 1'b1;
                        n_playing   = 1'b0;
                        n_elapsed   = '0;
                        need_second = (r_count != CNT_W'(1)) && !r_rd.last;
                        ev.last     = !need_second;
                    end else begin
                        n_elapsed = el_inc;
                    end
                end
            end
            ST_P2EMIT: begin
                ev_valid  = 1'b1;
                ev.kind   = EV_PLAY;
                ev.code   = r_rd.code;
                ev.vol    = r_volume;
                n_playing = 1'b1;
                n_elapsed = '0;
            end
            default: begin
            end
        endcase
        upd = (r_state == ST_EXEC || r_state == ST_P2EMIT) && (!ev_valid || out_free);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (upd) begin
                    n_state = need_second ? ST_P2WAIT : ST_IDLE;
                end
            end
            ST_P2WAIT: begin
                n_state = ST_P2EMIT;
            end
            ST_P2EMIT: begin
                if (upd) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // element store, read data always follows the head entry
    always_ff @(posedge i_clk) begin
        if (upd && wr_en) begin
            r_mem[wr_addr] <= '{last: r_item.last, dur: r_item.dur, code: r_item.code};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (upd && ev_valid) begin
            r_o <= ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_volume  <= VOLUME_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_qprio   <= '0;
            r_playing <= 1'b0;
            r_elapsed <= '0;
            r_mid     <= 1'b0;
            r_disc    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_volume <= i_cfg_wdata;
            end
            if (upd) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_count   <= n_count;
                r_qprio   <= n_qprio;
                r_playing <= n_playing;
                r_elapsed <= n_elapsed;
                r_mid     <= n_mid;
                r_disc    <= n_disc;
            end
            if (upd && ev_valid) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/priority_annunciation_sequencer_unit.sv =====
// flow: an accepted word waits in the input queue and is taken into the back-end item register
// when the sequencer is idle; its first result is registered at the output, and a play that
// follows a non-last stop is emitted from the emit state after the wait state and store read
// the sequencer takes a new word only when done with the last; a 4-word input queue decouples
// reset: synchronous active low, clears queues, pointers, counters, volume to full scale
`default_nettype none

module priority_annunciation_sequencer_unit #(
    parameter int QUEUE_DEPTH = pas_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sound_code[5:0], clip_duration[21:6], priority_req[24:22]
    input  logic        s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,   // end_of_announcement
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // clip_code[5:0], clip_volume[13:6]
    output logic [1:0]  m_axis_tuser,   // event_kind[1:0]
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import pas_pkg::*;

    t_item  item;
    logic   item_valid;
    logic   pop;
    t_event out_ev;

    pas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_is_tick    (s_axis_tuser),
        .i_code       (s_axis_tdata[5:0]),
        .i_dur        (s_axis_tdata[21:6]),
        .i_prio       (s_axis_tdata[24:22]),
        .i_last       (s_axis_tlast),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    pas_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out        (out_ev)
    );

    assign m_axis_tdata = {2'b00, out_ev.vol, out_ev.code};
    assign m_axis_tuser = out_ev.kind;
    assign m_axis_tlast = out_ev.last;

endmodule

`default_nettype wire

// ===== hdl/pas_checker.sv =====
// port-level checks for the priority annunciation sequencer, bound to the top level
// depends on pas_pkg and priority_annunciation_sequencer_unit_defines.svh
`default_nettype none
`include "priority_annunciation_sequencer_unit_defines.svh"

module pas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import pas_pkg::*;

    `PAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled word changed")

    `PAS_ASSERT_NOW(a_notice_clean,
        m_axis_tvalid && (m_axis_tuser == EV_DROP || m_axis_tuser == EV_FULL),
        m_axis_tdata == '0 && m_axis_tlast, "drop or full word carries clip data")

    `PAS_ASSERT_NOW(a_stop_no_vol, m_axis_tvalid && m_axis_tuser == EV_STOP,
        m_axis_tdata[13:6] == '0, "stop word carries a volume")

    `PAS_ASSERT_NEXT(a_stop_then_play, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        !m_axis_tvalid || m_axis_tuser == EV_PLAY, "word after a non-last stop is not a play")

    `PAS_ASSERT_NOW(a_nonlast_is_stop, m_axis_tvalid && !m_axis_tlast,
        m_axis_tuser == EV_STOP, "non-last word is not a stop")

endmodule

bind priority_annunciation_sequencer_unit pas_checker u_pas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
